// File: rtl/core/mwo_pkg.sv
package mwo_pkg;

  // Default build of the oscillator
  localparam int unsigned PhaseBitsDefault = 24;
  localparam int unsigned SineDepthDefault = 1024;

  // Field and datapath widths
  localparam int unsigned StartW   = 24;
  localparam int unsigned StepW    = 23;
  localparam int unsigned ShapeW   = 10;
  localparam int unsigned LevelW   = 16;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned FracW    = 8;
  localparam int unsigned SineMagW = 15;
  localparam int unsigned WaveW    = 17;
  localparam int unsigned DiffW    = 18;
  localparam int unsigned MixW     = 25;
  localparam int unsigned ProdW    = MixW + LevelW + 1;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Register reset values
  localparam logic [StepW-1:0]  StepReset  = StepW'(0);
  localparam logic [ShapeW-1:0] ShapeReset = ShapeW'(512);
  localparam logic [LevelW-1:0] LevelReset = LevelW'(27853);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PHASE_STEP = 2'd0,
    CFG_WAVE_SHAPE = 2'd1,
    CFG_OUT_LEVEL  = 2'd2
  } cfg_reg_e;

  // Waveforms along the morph axis
  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_TRI    = 2'd1,
    WAVE_SAW    = 2'd2,
    WAVE_SQUARE = 2'd3
  } wave_e;

  typedef struct packed {
    logic              restart;
    logic [StartW-1:0] start_phase;
  } mwo_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] wave_sample;
    logic                      wrapped;
  } mwo_out_t;

  // One quarter-wave entry, round(32767 * sin(k * step)), evaluated at elaboration
  function automatic logic [SineMagW-1:0] sine_mag(int k, real step);
    real v;
    v = 32767.0 * $sin(step * k);
    return SineMagW'($rtoi(v + 0.5));
  endfunction

endpackage

// File: rtl/core/mwo_serial_mul.sv
module mwo_serial_mul #(
  parameter int unsigned McandW  = mwo_pkg::MixW,
  parameter int unsigned MplierW = mwo_pkg::LevelW
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [McandW-1:0]        mcand_i,
  input  logic [MplierW-1:0]              mplier_i,
  output logic                            busy_o,
  output logic signed [McandW+MplierW:0]  prod_o
);

  localparam int unsigned CntW = $clog2(MplierW + 1);

  logic signed [McandW-1:0] mcand_q;
  logic signed [McandW:0]   hi_q;
  logic [MplierW-1:0]       lo_q;
  logic [CntW-1:0]          cnt_q;
  logic                     busy_q;
  logic signed [McandW+1:0] addend;
  logic signed [McandW+1:0] sum;

  // Add the multiplicand when the lowest multiplier bit is set
  assign addend = lo_q[0] ? (McandW+2)'(mcand_q) : '0;
  assign sum    = (McandW+2)'(hi_q) + addend;

  // Step counter: one multiplier bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == CntW'(MplierW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Shift the partial sum right, low product bits drop into the multiplier register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      hi_q    <= '0;
      lo_q    <= mplier_i;
    end else if (busy_q) begin
      hi_q <= sum[McandW+1:1];
      lo_q <= MplierW'({sum[0], lo_q} >> 1);
    end
  end

  assign busy_o = busy_q;
  assign prod_o = {hi_q, lo_q};

endmodule

// File: rtl/core/morphing_wave_oscillator_unit.sv
// Morphing wave oscillator: one beat on the input channel is one sample tick.
// Input beat: restart and start_phase. Output beat: wave_sample and wrapped.
// Both channels move a beat when valid is high and stall is low.
// The configuration channel writes phase_step (0), wave_shape (1) and
// out_level (2) whenever valid and ready are high; ready is always high and
// writes belong to idle periods.
// A new input beat is taken only once the previous tick has finished and its
// sample is loaded into the output register. The serial multiplier runs twice
// per tick (morph crossfade, then gain) at one multiplier bit a cycle over
// 16 bits; the bit-serial phase adder runs alongside it.
// While the output register holds an unaccepted sample the next input beat
// is still taken and worked on; it finishes only once the held beat leaves.
// Reset clears the phase to zero, loads the register defaults and empties
// the output register. SineTableDepth must be a power of two.
module morphing_wave_oscillator_unit #(
  parameter int unsigned PhaseBits      = mwo_pkg::PhaseBitsDefault,
  parameter int unsigned SineTableDepth = mwo_pkg::SineDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mwo_pkg::mwo_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mwo_pkg::mwo_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mwo_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mwo_pkg::CfgDataW-1:0]  cfg_data_i
);

  import mwo_pkg::*;

  localparam int unsigned AddrW     = $clog2(SineTableDepth);
  localparam int unsigned QuarterW  = AddrW - 2;
  localparam int unsigned Quarter   = SineTableDepth / 4;
  localparam real         SineStep  = 1.5707963267948966 / Quarter;
  localparam int unsigned PcntW     = $clog2(PhaseBits + 1);
  localparam int unsigned RoundBit  = 23;
  localparam int unsigned RndW      = ProdW - RoundBit;
  localparam int          RoundHalf = 1 << (RoundBit - 1);
  localparam int          SatMax    = 32767;
  localparam int          SatMin    = -32768;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WAVE = 4'b0010,
    ST_MIX  = 4'b0100,
    ST_GAIN = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [StepW-1:0]  step_q;
  logic [ShapeW-1:0] shape_q;
  logic [LevelW-1:0] level_q;

  logic [PhaseBits-1:0] ph_q;
  logic [PhaseBits-1:0] stp_q;
  logic                 carry_q;
  logic [PcntW-1:0]     pcnt_q;
  logic                 pbusy_q;
  logic                 sum_bit, carry_d;
  logic                 step_hi;

  logic                 in_beat;
  logic                 out_beat;
  logic                 finish;
  logic                 out_valid_q;
  mwo_out_t             out_q;

  logic [31:0]               pq;
  logic [SineMagW-1:0]       sine_rom [Quarter];
  logic [AddrW-1:0]          sidx;
  logic [QuarterW-1:0]       sj, sjm;
  logic [SineMagW-1:0]       smag;
  logic signed [WaveW-1:0]   sine_w, tri_w, saw_w, sq_w;
  logic [WaveW-1:0]          tri_abs;
  logic signed [WaveW:0]     tri_ext;
  wave_e                     a_code, b_code;
  logic [FracW-1:0]          frac;
  logic signed [WaveW-1:0]   wa, wb;
  logic signed [WaveW-1:0]   a_q;
  logic signed [DiffW-1:0]   diff;
  logic signed [MixW-1:0]    mix;

  logic                      mul_start;
  logic signed [MixW-1:0]    mul_mcand;
  logic [LevelW-1:0]         mul_mplier;
  logic                      mul_busy;
  logic signed [ProdW-1:0]   mul_prod;
  logic signed [ProdW-1:0]   rsum;
  logic signed [RndW-1:0]    rnd;
  logic signed [SampleW-1:0] sat;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= StepReset;
      shape_q <= ShapeReset;
      level_q <= LevelReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_PHASE_STEP: step_q  <= cfg_data_i[StepW-1:0];
        CFG_WAVE_SHAPE: shape_q <= cfg_data_i[ShapeW-1:0];
        CFG_OUT_LEVEL:  level_q <= cfg_data_i[LevelW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_beat    = in_valid_i && !in_stall_o;
  assign out_beat   = out_valid_q && !out_stall_i;
  assign finish     = (state_q == ST_GAIN) && !mul_busy && !pbusy_q &&
                      (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_beat) state_d = ST_WAVE;
      ST_WAVE: state_d = ST_MIX;
      ST_MIX:  if (!mul_busy) state_d = ST_GAIN;
      ST_GAIN: if (finish) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Phase accumulator: load on restart, then add the step one bit a cycle
  assign sum_bit = ph_q[0] ^ stp_q[0] ^ carry_q;
  assign carry_d = (ph_q[0] & stp_q[0]) | (carry_q & (ph_q[0] ^ stp_q[0]));
  assign step_hi = (step_q >> PhaseBits) != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= '0;
      pbusy_q <= 1'b0;
      pcnt_q  <= '0;
      carry_q <= 1'b0;
    end else if (in_beat) begin
      if (in_data_i.restart) begin
        ph_q <= PhaseBits'(in_data_i.start_phase);
      end
    end else if (state_q == ST_WAVE) begin
      pbusy_q <= 1'b1;
      pcnt_q  <= '0;
      carry_q <= 1'b0;
    end else if (pbusy_q) begin
      ph_q    <= {sum_bit, ph_q[PhaseBits-1:1]};
      carry_q <= carry_d;
      pcnt_q  <= pcnt_q + PcntW'(1);
      if (pcnt_q == PcntW'(PhaseBits - 1)) begin
        pbusy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WAVE) begin
      stp_q <= PhaseBits'(step_q);
    end else if (pbusy_q) begin
      stp_q <= stp_q >> 1;
    end
  end

  // Phase as a 32-bit fraction of a cycle
  assign pq = 32'(ph_q) << (32 - PhaseBits);

  // Quarter-wave sine table
  for (genvar k = 0; k < Quarter; k++) begin : g_sine
    assign sine_rom[k] = sine_mag(k, SineStep);
  end

  // Fold the sine index onto the first quarter; the peak sits past the table end
  assign sidx = pq[31 -: AddrW];
  assign sj   = sidx[QuarterW-1:0];
  assign sjm  = sidx[AddrW-2] ? QuarterW'(~sj + 1'b1) : sj;
  assign smag = (sidx[AddrW-2] && (sj == '0)) ? SineMagW'(SatMax) : sine_rom[sjm];

  always_comb begin
    sine_w  = WaveW'($signed({1'b0, smag}));
    if (sidx[AddrW-1]) begin
      sine_w = -sine_w;
    end
    tri_abs = pq[31] ? {1'b0, pq[30:15]} : (WaveW'(65536) - {1'b0, pq[30:15]});
    tri_ext = $signed({1'b0, tri_abs}) - (WaveW+1)'(32768);
    tri_w   = tri_ext[WaveW-1:0];
    saw_w   = $signed(WaveW'(32768) - {1'b0, pq[31:16]});
    sq_w    = pq[31] ? $signed(WaveW'(SatMin)) : $signed(WaveW'(32768));
  end

  // Pick the two neighbouring waves; clamp to pure square at the top
  always_comb begin
    a_code = wave_e'(shape_q[ShapeW-1:FracW]);
    b_code = wave_e'(shape_q[ShapeW-1:FracW] + 2'd1);
    frac   = shape_q[FracW-1:0];
    if (a_code == WAVE_SQUARE) begin
      b_code = WAVE_SQUARE;
      frac   = '0;
    end
    case (a_code)
      WAVE_SINE: wa = sine_w;
      WAVE_TRI:  wa = tri_w;
      WAVE_SAW:  wa = saw_w;
      default:   wa = sq_w;
    endcase
    case (b_code)
      WAVE_SINE: wb = sine_w;
      WAVE_TRI:  wb = tri_w;
      WAVE_SAW:  wb = saw_w;
      default:   wb = sq_w;
    endcase
  end

  assign diff = DiffW'(wb) - DiffW'(wa);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WAVE) begin
      a_q <= wa;
    end
  end

  // Crossfade a*256 + (b-a)*f, then scale by the level
  assign mix = (MixW'(a_q) <<< FracW) + mul_prod[MixW-1:0];

  assign mul_start  = (state_q == ST_WAVE) || ((state_q == ST_MIX) && !mul_busy);
  assign mul_mcand  = (state_q == ST_WAVE) ? MixW'(diff) : mix;
  assign mul_mplier = (state_q == ST_WAVE) ? LevelW'(frac) : level_q;

  mwo_serial_mul #(
    .McandW  (MixW),
    .MplierW (LevelW)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_mcand),
    .mplier_i (mul_mplier),
    .busy_o   (mul_busy),
    .prod_o   (mul_prod)
  );

  // Round half up and saturate
  assign rsum = mul_prod + ProdW'(RoundHalf);
  assign rnd  = rsum[ProdW-1:RoundBit];

  always_comb begin
    if (rnd > SatMax) begin
      sat = SampleW'(SatMax);
    end else if (rnd < SatMin) begin
      sat = SampleW'(SatMin);
    end else begin
      sat = rnd[SampleW-1:0];
    end
  end

  // Output register: hold the beat until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_beat) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_q.wave_sample <= sat;
      out_q.wrapped     <= carry_q | step_hi;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/mwo_checker.sv
module mwo_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input mwo_pkg::mwo_out_t out_data_o
);

  import mwo_pkg::*;

  // Hold a stalled output beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // One tick in flight: a taken beat closes the input side
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a beat");

  // A new sample only appears at the end of a tick in progress
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("sample appeared with no tick in progress");

endmodule

bind morphing_wave_oscillator_unit mwo_checker u_mwo_checker (.*);

// File: tb/sv/morphing_wave_oscillator_unit_test.sv
module morphing_wave_oscillator_unit_test;
  import mwo_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandPhases  = 8;
  localparam int unsigned PhaseBeats  = 100;
  localparam int unsigned SettleTicks = 40;
  localparam int unsigned ReportMax   = 10;
  localparam real         TwoPi       = 6.283185307179586476925;

  // One directed stimulus row: optional register load, then one input beat
  typedef struct {
    bit                load;
    logic [StepW-1:0]  step;
    logic [ShapeW-1:0] shape;
    logic [LevelW-1:0] level;
    mwo_in_t           beat;
    bit                typed;
    mwo_out_t          want;
  } drill_t;

  // Hand-typed expectation travelling with an input beat
  typedef struct {
    bit       typed;
    mwo_out_t want;
  } pinned_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  mwo_in_t           in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  mwo_out_t          out_data_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // Predictor copy of the oscillator state and registers
  logic [StartW-1:0] phase_acc = '0;
  logic [StepW-1:0]  step_reg  = StepReset;
  logic [ShapeW-1:0] shape_reg = ShapeReset;
  logic [LevelW-1:0] level_reg = LevelReset;
  int                sine_lut [SineDepthDefault];

  mwo_out_t    sample_q [$];
  pinned_t     pinned_q [$];
  drill_t      drills [$];
  pinned_t     pin_now;
  mwo_out_t    sample_now;
  mwo_out_t    sample_want;
  logic [StartW:0] phase_sum;

  int unsigned ticks_in   = 0;
  int unsigned ticks_out  = 0;
  int unsigned reg_writes = 0;
  int unsigned reg_loads  = 0;
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  int unsigned stall_left = 0;
  bit          idle_on    = 1'b1;

  morphing_wave_oscillator_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Value of one waveform at phase p, full scale 32768
  function automatic int wave_at(wave_e w, logic [StartW-1:0] p);
    int d;
    case (w)
      WAVE_SINE: return sine_lut[p[StartW-1 -: 10]];
      WAVE_TRI: begin
        d = int'(p[StartW-1:7]) - 65536;
        if (d < 0) d = -d;
        return d - 32768;
      end
      WAVE_SAW: return 32768 - int'(p[StartW-1:8]);
      default: return p[StartW-1] ? -32768 : 32768;
    endcase
  endfunction

  // Crossfade the two neighbouring waves, apply gain, round half up, saturate
  function automatic logic signed [SampleW-1:0] morph_gain(logic [StartW-1:0] p,
                                                          logic [ShapeW-1:0] shape,
                                                          logic [LevelW-1:0] level);
    longint mix;
    longint prod;
    longint r;
    int     fr;
    wave_e  w;
    if (shape == '0) begin
      mix = longint'(wave_at(WAVE_SINE, p)) * 256;
    end else if (shape >= ShapeW'(768)) begin
      mix = longint'(wave_at(WAVE_SQUARE, p)) * 256;
    end else begin
      w   = wave_e'(shape[ShapeW-1:FracW]);
      fr  = int'(shape[FracW-1:0]);
      mix = longint'(wave_at(w, p)) * (256 - fr)
          + longint'(wave_at(wave_e'(shape[ShapeW-1:FracW] + 2'd1), p)) * fr;
    end
    prod = mix * longint'(level);
    r    = (prod + 64'sd4194304) >>> 23;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[SampleW-1:0];
  endfunction

  task automatic flag_mismatch(string what);
    mismatches++;
    if (mismatches <= ReportMax) $display("mismatch: %s", what);
  endtask

  // Track register writes on the configuration channel
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      reg_writes++;
      case (cfg_reg_e'(cfg_index_i))
        CFG_PHASE_STEP: step_reg  = cfg_data_i[StepW-1:0];
        CFG_WAVE_SHAPE: shape_reg = cfg_data_i[ShapeW-1:0];
        CFG_OUT_LEVEL:  level_reg = cfg_data_i[LevelW-1:0];
        default: ;
      endcase
    end
  end

  // Predict the sample for each accepted input beat and advance the phase
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      ticks_in++;
      if (in_data_i.restart) phase_acc = in_data_i.start_phase;
      sample_now.wave_sample = morph_gain(phase_acc, shape_reg, level_reg);
      phase_sum              = {1'b0, phase_acc} + (StartW + 1)'(step_reg);
      sample_now.wrapped     = phase_sum[StartW];
      phase_acc              = phase_sum[StartW-1:0];
      pin_now = pinned_q.pop_front();
      sample_q.push_back(pin_now.typed ? pin_now.want : sample_now);
    end
  end

  // Compare each accepted output beat with the oldest expected sample
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      ticks_out++;
      if (sample_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat sample %0d wrapped %0b",
                                out_data_o.wave_sample, out_data_o.wrapped));
      end else begin
        sample_want = sample_q.pop_front();
        if (out_data_o.wave_sample !== sample_want.wave_sample ||
            out_data_o.wrapped !== sample_want.wrapped)
          flag_mismatch($sformatf("tick %0d: sample %0d/%0d wrapped %0b/%0b (want/got)",
                                  ticks_out, sample_want.wave_sample,
                                  out_data_o.wave_sample, sample_want.wrapped,
                                  out_data_o.wrapped));
      end
    end
  end

  // Output back-pressure in random bursts, started only while idle_on is set
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left  <= $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("morphing_wave_oscillator_unit test failed");
      $finish;
    end
  end

  task automatic add_drill(bit load, logic [StepW-1:0] step, logic [ShapeW-1:0] shape,
                           logic [LevelW-1:0] level, logic restart,
                           logic [StartW-1:0] start, bit typed,
                           logic signed [SampleW-1:0] smp, logic wrap);
    drill_t d;
    d.load  = load;
    d.step  = step;
    d.shape = shape;
    d.level = level;
    d.beat  = '{restart: restart, start_phase: start};
    d.typed = typed;
    d.want  = '{wave_sample: smp, wrapped: wrap};
    drills.push_back(d);
  endtask

  // Hold each register write until taken; upper data bits carry junk
  task automatic load_regs(logic [StepW-1:0] st, logic [ShapeW-1:0] sh,
                           logic [LevelW-1:0] lv);
    cfg_reg_e            r;
    logic [CfgDataW-1:0] d;
    reg_loads++;
    cfg_valid_i <= 1'b1;
    for (int k = 0; k < 3; k++) begin
      r = cfg_reg_e'(k);
      d = $urandom;
      case (r)
        CFG_PHASE_STEP: d[StepW-1:0]  = st;
        CFG_WAVE_SHAPE: d[ShapeW-1:0] = sh;
        default:        d[LevelW-1:0] = lv;
      endcase
      cfg_index_i <= r;
      cfg_data_i  <= d;
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Drive one input beat, with an optional idle burst in front of it
  task automatic send_beat(mwo_in_t b, bit typed, mwo_out_t want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    pinned_q.push_back('{typed: typed, want: want});
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and wait for every outstanding sample
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sample_q.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  initial begin
    int      u;
    bit      neg;
    int      v;
    mwo_in_t b;
    logic [StepW-1:0]  st;
    logic [ShapeW-1:0] sh;
    logic [LevelW-1:0] lv;

    // Sine table from quarter-wave symmetry
    for (int i = 0; i < SineDepthDefault; i++) begin
      neg = (i >= 512);
      if (i < 256) u = i;
      else if (i < 512) u = 512 - i;
      else if (i < 768) u = i - 512;
      else u = 1024 - i;
      v = $rtoi(32767.0 * $sin(TwoPi * u / 1024.0) + 0.5);
      sine_lut[i] = neg ? -v : v;
    end

    // Directed rows: reset defaults, each pure wave at its extremes, gain,
    // restart and phase wrap with the largest step
    add_drill(0, 0, 0, 0, 0, 24'h000000, 1, 16'sd27853, 0);
    add_drill(0, 0, 0, 0, 1, 24'h800000, 1, 16'sd0, 0);
    add_drill(1, 0, 0, 16'd32768, 1, 24'h400000, 1, 16'sd32767, 0);
    add_drill(0, 0, 0, 0, 1, 24'hC00000, 1, -16'sd32767, 0);
    add_drill(0, 0, 0, 0, 1, 24'h000000, 1, 16'sd0, 0);
    add_drill(1, 0, 10'd256, 16'd32768, 1, 24'h000000, 1, 16'sd32767, 0);
    add_drill(0, 0, 0, 0, 1, 24'h800000, 1, -16'sd32768, 0);
    add_drill(1, 0, 10'd512, 16'd32768, 1, 24'hFFFFFF, 1, -16'sd32767, 0);
    add_drill(1, 23'h7FFFFF, 10'd768, 16'd65535, 1, 24'hFFFFFF, 1, -16'sd32768, 1);
    add_drill(0, 0, 0, 0, 0, 24'h000000, 1, 16'sd32767, 0);
    add_drill(0, 0, 0, 0, 0, 24'h000000, 1, -16'sd32768, 1);
    add_drill(1, 23'h7FFFFF, 10'd1023, 16'd0, 1, 24'h123456, 1, 16'sd0, 0);
    add_drill(1, 23'h001000, 10'd384, 16'd40000, 1, 24'h0ABCDE, 0, 0, 0);
    add_drill(0, 0, 0, 0, 0, 24'h000000, 0, 0, 0);
    add_drill(0, 0, 0, 0, 0, 24'hFFFFFF, 0, 0, 0);
    add_drill(1, 23'h2AAAAA, 10'd640, 16'd65535, 1, 24'hFFFFFF, 0, 0, 0);
    add_drill(0, 0, 0, 0, 0, 24'h000000, 0, 0, 0);
    add_drill(0, 0, 0, 0, 1, 24'h555555, 0, 0, 0);
    add_drill(0, 0, 0, 0, 0, 24'h000000, 0, 0, 0);
    add_drill(1, 23'h555555, 10'd128, 16'd1, 0, 24'h000000, 0, 0, 0);
    add_drill(0, 0, 0, 0, 1, 24'h800000, 0, 0, 0);

    // Reset
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (drills[i]) begin
      if (drills[i].load) begin
        drain();
        load_regs(drills[i].step, drills[i].shape, drills[i].level);
      end
      send_beat(drills[i].beat, drills[i].typed, drills[i].want);
    end

    // Random phases: first at the maxima, then the minima, then mixed
    for (int ph = 0; ph < RandPhases; ph++) begin
      if (ph == 0) begin
        st = 23'h7FFFFF;
        sh = 10'd1023;
        lv = 16'hFFFF;
      end else if (ph == 1) begin
        st = '0;
        sh = '0;
        lv = '0;
      end else begin
        case ($urandom_range(0, 3))
          0:       st = '0;
          1:       st = 23'h7FFFFF;
          2:       st = StepW'($urandom_range(0, 4095));
          default: st = StepW'($urandom);
        endcase
        case ($urandom_range(0, 5))
          0:       sh = '0;
          1:       sh = 10'd256;
          2:       sh = 10'd512;
          3:       sh = 10'd768;
          4:       sh = 10'd1023;
          default: sh = ShapeW'($urandom);
        endcase
        case ($urandom_range(0, 4))
          0:       lv = '0;
          1:       lv = 16'd32768;
          2:       lv = 16'hFFFF;
          default: lv = LevelW'($urandom);
        endcase
      end
      drain();
      load_regs(st, sh, lv);
      // Quiet last phase; otherwise idling in most phases
      idle_on = (ph != RandPhases - 1) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PhaseBeats; n++) begin
        b.restart     = ($urandom_range(0, 5) == 0);
        b.start_phase = StartW'($urandom);
        send_beat(b, 1'b0, '0);
      end
    end

    drain();
    repeat (SettleTicks) @(posedge clk_i);

    $display("%0d sample ticks in, %0d checked, %0d register writes over %0d settings",
             ticks_in, ticks_out, reg_writes, reg_loads);
    $display("%0d mismatches, %0d samples still outstanding", mismatches, sample_q.size());
    if (mismatches == 0 && sample_q.size() == 0) begin
      $display("morphing_wave_oscillator_unit test passed");
    end else begin
      $display("morphing_wave_oscillator_unit test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/mwo_pkg.sv
rtl/core/mwo_serial_mul.sv
rtl/core/morphing_wave_oscillator_unit.sv
rtl/core/mwo_checker.sv
tb/sv/morphing_wave_oscillator_unit_test.sv
